[rtl/core/tls_pkg.sv]
// ---------------------------------------------------------------------------
// tls_pkg
// Shared types and constants of the text line segmenter.
// ---------------------------------------------------------------------------
package tls_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;

    // coordinate and count widths of the reported fields
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int IDX_W     = 10;

    // configuration port
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET    = 11'd1024;
    localparam logic [DIM_W-1:0] MAX_COLS_DIM = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] MAX_ROWS_DIM = DIM_W'(MAX_ROWS);

    // last column and last row index after clamping the dimensions
    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } dims_t;

    typedef struct packed {
        logic [IDX_W-1:0] line_index;
        logic [ROW_W-1:0] top_row;
        logic [ROW_W-1:0] bottom_row;
        logic [COL_W-1:0] first_col;
        logic [COL_W-1:0] last_col;
    } line_rec_t;

    // handshake between the tracker and the result register
    typedef struct packed {
        logic      push;
        line_rec_t rec;
    } result_req_t;

endpackage

[rtl/core/tls_pixel_if.sv]
// ---------------------------------------------------------------------------
// tls_pixel_if
// Pixel stream channel: one bi-level pixel per request.
// ---------------------------------------------------------------------------
interface tls_pixel_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/core/tls_line_if.sv]
// ---------------------------------------------------------------------------
// tls_line_if
// Line result channel: one detected text line per request.
// ---------------------------------------------------------------------------
interface tls_line_if;
    logic                      valid;
    logic                      ready;
    logic [tls_pkg::IDX_W-1:0] line_index;
    logic [tls_pkg::ROW_W-1:0] top_row;
    logic [tls_pkg::ROW_W-1:0] bottom_row;
    logic [tls_pkg::COL_W-1:0] first_col;
    logic [tls_pkg::COL_W-1:0] last_col;

    modport source (output valid, output line_index, output top_row, output bottom_row,
                    output first_col, output last_col, input ready);
    modport sink   (input valid, input line_index, input top_row, input bottom_row,
                    input first_col, input last_col, output ready);
endinterface

[rtl/core/tls_cfg_regs.sv]
// ---------------------------------------------------------------------------
// tls_cfg_regs
// Image size registers, clamped to the supported range.
// ---------------------------------------------------------------------------
module tls_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tls_pkg::DIM_W-1:0]     cfg_data,
    output tls_pkg::dims_t                dims
);
    import tls_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb
    begin
        if (width_reg == '0)
            dims.col_last = '0;
        else if (width_reg >= MAX_COLS_DIM)
            dims.col_last = COL_W'(MAX_COLS_DIM - 11'd1);
        else
            dims.col_last = COL_W'(width_reg - 11'd1);

        if (height_reg == '0)
            dims.row_last = '0;
        else if (height_reg >= MAX_ROWS_DIM)
            dims.row_last = ROW_W'(MAX_ROWS_DIM - 11'd1);
        else
            dims.row_last = ROW_W'(height_reg - 11'd1);
    end

endmodule

[rtl/core/tls_line_tracker.sv]
// ---------------------------------------------------------------------------
// tls_line_tracker
// Input register, row and line running state, and line emit decision.
// ---------------------------------------------------------------------------
module tls_line_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    tls_pixel_if.sink            pixels,
    input  tls_pkg::dims_t       dims,
    input  logic                 slot_free,
    output tls_pkg::result_req_t res
);
    import tls_pkg::*;

    logic             in_vld_reg, in_vld_next;
    logic             px_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_has_reg, row_has_next;
    logic [COL_W-1:0] row_min_reg, row_min_next;
    logic [COL_W-1:0] row_max_reg, row_max_next;
    logic             line_open_reg, line_open_next;
    logic [ROW_W-1:0] line_top_reg, line_top_next;
    logic [COL_W-1:0] line_min_reg, line_min_next;
    logic [COL_W-1:0] line_max_reg, line_max_next;
    logic [IDX_W-1:0] lines_reg, lines_next;

    logic             rh_c;
    logic [COL_W-1:0] rmin_c, rmax_c;
    logic             row_end, last_row, emit, fire;
    logic [ROW_W-1:0] top_c;
    logic [COL_W-1:0] lmin_c, lmax_c;

    assign fire          = in_vld_reg && (!emit || slot_free);
    assign pixels.ready  = !in_vld_reg || fire;
    assign in_vld_next   = (pixels.valid && pixels.ready) || (in_vld_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (pixels.valid && pixels.ready)
            px_reg <= pixels.pixel;
    end

    always_comb
    begin
        // row extent including the current pixel
        rh_c   = row_has_reg || px_reg;
        rmin_c = row_min_reg;
        rmax_c = row_max_reg;
        if (px_reg)
        begin
            if (!row_has_reg)
            begin
                rmin_c = col_reg;
                rmax_c = col_reg;
            end
            else
            begin
                if (col_reg < row_min_reg) rmin_c = col_reg;
                if (col_reg > row_max_reg) rmax_c = col_reg;
            end
        end

        row_end  = col_reg >= dims.col_last;
        last_row = row_reg >= dims.row_last;

        // line extent once this row is merged in
        top_c  = line_top_reg;
        lmin_c = line_min_reg;
        lmax_c = line_max_reg;
        if (!line_open_reg)
        begin
            top_c  = row_reg;
            lmin_c = rmin_c;
            lmax_c = rmax_c;
        end
        else
        begin
            if (rmin_c < line_min_reg) lmin_c = rmin_c;
            if (rmax_c > line_max_reg) lmax_c = rmax_c;
        end

        emit                = 1'b0;
        res.rec.line_index  = lines_reg;
        res.rec.top_row     = line_top_reg;
        res.rec.bottom_row  = row_reg - 10'd1;
        res.rec.first_col   = line_min_reg;
        res.rec.last_col    = line_max_reg;
        if (in_vld_reg && row_end)
        begin
            if (rh_c && last_row)
            begin
                emit               = 1'b1;
                res.rec.top_row    = top_c;
                res.rec.bottom_row = row_reg;
                res.rec.first_col  = lmin_c;
                res.rec.last_col   = lmax_c;
            end
            else if (!rh_c && line_open_reg)
            begin
                emit = 1'b1;
            end
        end
        res.push = fire && emit;

        col_next       = col_reg;
        row_next       = row_reg;
        row_has_next   = row_has_reg;
        row_min_next   = row_min_reg;
        row_max_next   = row_max_reg;
        line_open_next = line_open_reg;
        line_top_next  = line_top_reg;
        line_min_next  = line_min_reg;
        line_max_next  = line_max_reg;
        lines_next     = lines_reg;

        if (fire)
        begin
            if (!row_end)
            begin
                col_next     = col_reg + 10'd1;
                row_has_next = rh_c;
                row_min_next = rmin_c;
                row_max_next = rmax_c;
            end
            else if (last_row)
            begin
                // frame restart
                col_next       = '0;
                row_next       = '0;
                row_has_next   = 1'b0;
                row_min_next   = '1;
                row_max_next   = '0;
                line_open_next = 1'b0;
                line_top_next  = '0;
                line_min_next  = '1;
                line_max_next  = '0;
                lines_next     = '0;
            end
            else
            begin
                col_next     = '0;
                row_next     = row_reg + 10'd1;
                row_has_next = 1'b0;
                row_min_next = '1;
                row_max_next = '0;
                if (rh_c)
                begin
                    line_open_next = 1'b1;
                    line_top_next  = top_c;
                    line_min_next  = lmin_c;
                    line_max_next  = lmax_c;
                end
                else if (line_open_reg)
                begin
                    line_open_next = 1'b0;
                    lines_next     = lines_reg + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_has_reg   <= 1'b0;
            row_min_reg   <= '1;
            row_max_reg   <= '0;
            line_open_reg <= 1'b0;
            line_top_reg  <= '0;
            line_min_reg  <= '1;
            line_max_reg  <= '0;
            lines_reg     <= '0;
        end
        else
        begin
            in_vld_reg    <= in_vld_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_has_reg   <= row_has_next;
            row_min_reg   <= row_min_next;
            row_max_reg   <= row_max_next;
            line_open_reg <= line_open_next;
            line_top_reg  <= line_top_next;
            line_min_reg  <= line_min_next;
            line_max_reg  <= line_max_next;
            lines_reg     <= lines_next;
        end
    end

endmodule

[rtl/core/tls_out_reg.sv]
// ---------------------------------------------------------------------------
// tls_out_reg
// Result register driving the line channel.
// ---------------------------------------------------------------------------
module tls_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  tls_pkg::result_req_t res,
    output logic                slot_free,
    tls_line_if.source          lines
);
    import tls_pkg::*;

    logic      out_vld_reg, out_vld_next;
    line_rec_t rec_reg;

    assign slot_free    = !out_vld_reg || lines.ready;
    assign out_vld_next = res.push || (out_vld_reg && !lines.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
            rec_reg <= res.rec;
    end

    assign lines.valid      = out_vld_reg;
    assign lines.line_index = rec_reg.line_index;
    assign lines.top_row    = rec_reg.top_row;
    assign lines.bottom_row = rec_reg.bottom_row;
    assign lines.first_col  = rec_reg.first_col;
    assign lines.last_col   = rec_reg.last_col;

endmodule

[rtl/core/text_line_segmenter.sv]
// ---------------------------------------------------------------------------
// text_line_segmenter
// Finds text lines in a raster bi-level image by horizontal projection.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                         request
//  pixels    in   pixel                                           one pixel
//  lines     out  line_index top_row bottom_row first_col last_col one line
//  cfg_*     in   cfg_index cfg_data                              reg write
//
//  one pixel per clock sustained; a pixel passes an input register and the
//  running row/line min-max update, a line lands in the result register.
//  a line goes valid when its closing pixel fires out of the input register.
//  rst_n clears counters, open line and line count; sizes reset to 1024.
//  a stalled result holds the tracker only on a pixel that emits a line.
// ---------------------------------------------------------------------------
module text_line_segmenter (
    input  logic                          clk,
    input  logic                          rst_n,
    tls_pixel_if.sink                     pixels,
    tls_line_if.source                    lines,
    input  logic                          cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tls_pkg::DIM_W-1:0]     cfg_data
);
    import tls_pkg::*;

    dims_t       dims;
    result_req_t res;
    logic        slot_free;

    tls_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims)
    );

    tls_line_tracker u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .dims      (dims),
        .slot_free (slot_free),
        .res       (res)
    );

    tls_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .slot_free (slot_free),
        .lines     (lines)
    );

endmodule

[test/tls_line_checker.sv]
// ---------------------------------------------------------------------------
// tls_line_checker
// Watches the pixel, line and register ports of the text line segmenter,
// tracks rows and lines of the raster on its own, and compares every line
// request against the oldest line it has predicted.
// ---------------------------------------------------------------------------
module tls_line_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    input  logic                          pix_ready,
    input  logic                          pix,
    input  logic                          line_valid,
    input  logic                          line_ready,
    input  tls_pkg::line_rec_t            line_seen,
    input  logic                          cfg_we,
    input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tls_pkg::DIM_W-1:0]     cfg_data,
    output int                            error_count,
    output int                            lines_pending,
    output int                            lines_checked
);
    import tls_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // raster position and running extents
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;
    logic             row_hit;
    logic [COL_W-1:0] row_lo;
    logic [COL_W-1:0] row_hi;
    logic             line_active;
    logic [ROW_W-1:0] line_top;
    logic [COL_W-1:0] line_lo;
    logic [COL_W-1:0] line_hi;
    logic [IDX_W-1:0] line_count;

    line_rec_t expected_lines[$];

    function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int limit);
        if (raw == '0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    task automatic restart_frame();
        col_pos     = '0;
        row_pos     = '0;
        row_hit     = 1'b0;
        row_lo      = '1;
        row_hi      = '0;
        line_active = 1'b0;
        line_top    = '0;
        line_lo     = '1;
        line_hi     = '0;
        line_count  = '0;
    endtask

    task automatic close_line(input logic [ROW_W-1:0] bottom);
        line_rec_t rec;
        rec.line_index = line_count;
        rec.top_row    = line_top;
        rec.bottom_row = bottom;
        rec.first_col  = line_lo;
        rec.last_col   = line_hi;
        expected_lines.push_back(rec);
        line_count = line_count + 1'b1;
    endtask

    task automatic track_pixel(input logic px);
        int   w;
        int   h;
        logic last_row;
        w = clamp_dim(width_reg, MAX_COLS);
        h = clamp_dim(height_reg, MAX_ROWS);
        if (px)
        begin
            if (!row_hit)
            begin
                row_lo = col_pos;
                row_hi = col_pos;
            end
            else
            begin
                if (col_pos < row_lo)
                    row_lo = col_pos;
                if (col_pos > row_hi)
                    row_hi = col_pos;
            end
            row_hit = 1'b1;
        end
        if (int'(col_pos) + 1 < w)
        begin
            col_pos = col_pos + 1'b1;
        end
        else
        begin
            // a shrunk size ends the row or frame at once
            last_row = (int'(row_pos) + 1 >= h);
            if (row_hit)
            begin
                if (!line_active)
                begin
                    line_active = 1'b1;
                    line_top    = row_pos;
                    line_lo     = row_lo;
                    line_hi     = row_hi;
                end
                else
                begin
                    if (row_lo < line_lo)
                        line_lo = row_lo;
                    if (row_hi > line_hi)
                        line_hi = row_hi;
                end
                if (last_row)
                    close_line(row_pos);
            end
            else if (line_active)
            begin
                close_line(row_pos - 1'b1);
                line_active = 1'b0;
            end
            if (last_row)
            begin
                restart_frame();
            end
            else
            begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
                row_hit = 1'b0;
                row_lo  = '1;
                row_hi  = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_rec_t want;
        if (!rst_n)
        begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            restart_frame();
            expected_lines.delete();
            error_count   = 0;
            lines_checked = 0;
            lines_pending = 0;
        end
        else
        begin
            if (line_valid && line_ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected line: idx %0d rows %0d..%0d cols %0d..%0d",
                                 line_seen.line_index, line_seen.top_row,
                                 line_seen.bottom_row, line_seen.first_col,
                                 line_seen.last_col);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    lines_checked++;
                    if (line_seen.line_index !== want.line_index ||
                        line_seen.top_row    !== want.top_row    ||
                        line_seen.bottom_row !== want.bottom_row ||
                        line_seen.first_col  !== want.first_col  ||
                        line_seen.last_col   !== want.last_col)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"line mismatch: expected idx %0d rows %0d..%0d ",
                                      "cols %0d..%0d, got idx %0d rows %0d..%0d ",
                                      "cols %0d..%0d"},
                                     want.line_index, want.top_row, want.bottom_row,
                                     want.first_col, want.last_col,
                                     line_seen.line_index, line_seen.top_row,
                                     line_seen.bottom_row, line_seen.first_col,
                                     line_seen.last_col);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data;
            end
            if (pix_valid && pix_ready)
                track_pixel(pix);
            lines_pending = expected_lines.size();
        end
    end

endmodule

[test/tb_text_line_segmenter.sv]
// ---------------------------------------------------------------------------
// tb_text_line_segmenter
// Drives bi-level raster frames into the text line segmenter under a range
// of image sizes, with random gaps on the pixel side and random back-pressure
// on the line side; a checker beside the block predicts and compares lines.
// ---------------------------------------------------------------------------
module tb_text_line_segmenter;
    import tls_pkg::*;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_FULL     = 1;
    localparam int IDLE_SPARSE   = 2;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 330;

    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    int error_count;
    int lines_pending;
    int lines_checked;

    int tx_mode = IDLE_NONE;
    int rx_mode = IDLE_NONE;
    int cur_width;
    int pixels_sent;
    int phase_count;
    int quiet_cycles = 0;

    tls_pixel_if pix_ch();
    tls_line_if  line_ch();

    text_line_segmenter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .lines     (line_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tls_line_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_ch.valid),
        .pix_ready     (pix_ch.ready),
        .pix           (pix_ch.pixel),
        .line_valid    (line_ch.valid),
        .line_ready    (line_ch.ready),
        .line_seen     ({line_ch.line_index, line_ch.top_row, line_ch.bottom_row,
                         line_ch.first_col, line_ch.last_col}),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .lines_pending (lines_pending),
        .lines_checked (lines_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_draw(input int mode);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_SPARSE && $urandom_range(0, 7) != 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // line side: hold ready low for a drawn number of cycles per request
    initial
    begin
        int rx_wait;
        rx_wait = 0;
        line_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_wait > 0)
            begin
                line_ch.ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                line_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (line_ch.valid && line_ch.ready)
                rx_wait = idle_draw(rx_mode);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (line_ch.valid && line_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
                $display("[text_line_segmenter] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_pixel(input logic p);
        int gap;
        gap = idle_draw(tx_mode);
        repeat (gap)
        begin
            @(negedge clk);
            pix_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
    endtask

    // sizes change only once every predicted line is out and the pipe is quiet
    task automatic configure(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
        do
            @(negedge clk);
        while (lines_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w_raw;
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_width = (w_raw == '0) ? 1 : ((int'(w_raw) > MAX_COLS) ? MAX_COLS : int'(w_raw));
        tx_mode   = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        rx_mode   = $urandom_range(IDLE_NONE, IDLE_SPARSE);
    endtask

    // rows of text bands and blank gaps; first row spans the full width
    task automatic run_phase(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                             input int rows, input int extra);
        int   lo;
        int   hi;
        int   dens;
        bit   in_text;
        bit   noisy;
        logic p;
        configure(w_raw, h_raw);
        in_text = 1'b1;
        for (int r = 0; r < rows; r++)
        begin
            noisy = (r != 0) && ($urandom_range(0, 9) == 0);
            if (r == 0)
            begin
                lo = 0;
                hi = cur_width - 1;
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    in_text = !in_text;
                lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, cur_width - 1);
                hi = ($urandom_range(0, 3) == 0) ? cur_width - 1
                                                 : $urandom_range(lo, cur_width - 1);
            end
            dens = $urandom_range(10, 100);
            for (int c = 0; c < cur_width; c++)
            begin
                if (noisy)
                    p = 1'($urandom_range(0, 1));
                else
                    p = in_text && (c == lo || c == hi ||
                                    (c > lo && c < hi && $urandom_range(1, 100) <= dens));
                push_pixel(p);
            end
        end
        // partial row so that the next size change lands mid-row
        repeat (extra) push_pixel(1'($urandom_range(0, 1)));
        end_burst();
        phase_count++;
    endtask

    initial
    begin
        logic [23:0] demo_bits;
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        int   w_eff;
        int   start_count;

        rst_n        = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        pixels_sent  = 0;
        phase_count  = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // 3x4 frames: line in the middle, single-pixel line, line on bottom edge
        demo_bits = 24'b000_010_101_000_001_000_100_011;
        configure(11'd3, 11'd4);
        tx_mode = IDLE_SPARSE;
        rx_mode = IDLE_SPARSE;
        for (int i = 23; i >= 0; i--)
            push_pixel(demo_bits[i]);
        end_burst();
        phase_count++;

        // saturated sizes, then both shrunk in the middle of a row
        run_phase(11'd2047, 11'd2047, 0, 5);
        run_phase(11'd6, 11'd0, 8, 2);
        run_phase(11'd0, 11'd5, 30, 0);
        run_phase(11'd0, 11'd0, 40, 0);
        // one full row at the saturated width, line on the bottom edge
        run_phase(11'd2047, 11'd1, 1, 0);

        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            w_raw = ($urandom_range(0, 9) == 0) ? 11'd0 : DIM_W'($urandom_range(1, 16));
            case ($urandom_range(0, 9))
                0:       h_raw = 11'd0;
                1:       h_raw = DIM_W'($urandom_range(1025, 2047));
                default: h_raw = DIM_W'($urandom_range(1, 12));
            endcase
            w_eff = (w_raw == '0) ? 1 : int'(w_raw);
            run_phase(w_raw, h_raw, $urandom_range(2, 160 / w_eff),
                      ($urandom_range(0, 1) == 0) ? $urandom_range(0, w_eff - 1) : 0);
        end

        do
            @(negedge clk);
        while (lines_pending != 0);
        repeat (8) @(negedge clk);

        $display("sent %0d pixels over %0d size settings, %0d lines compared",
                 pixels_sent, phase_count, lines_checked);
        $display("sizes from 1x1 up to a full 1024-pixel row, zero and oversized values and mid-row size changes included");
        if (error_count == 0 && lines_pending == 0)
            $display("[text_line_segmenter] OK");
        else
            $display("[text_line_segmenter] ERROR");
        $finish;
    end

endmodule
